// ===== hw/rtl/rtlp_pkg.sv =====
// shared types and character constants for the radar text line parser
`default_nettype none

package rtlp_pkg;

  localparam int unsigned RANGE_W = 17;

  typedef logic [7:0]                byte_t;
  typedef logic signed [RANGE_W-1:0] range_t;

  localparam byte_t CHAR_CR    = 8'h0D;
  localparam byte_t CHAR_LF    = 8'h0A;
  localparam byte_t CHAR_O     = 8'h4F;
  localparam byte_t CHAR_F     = 8'h46;
  localparam byte_t CHAR_N     = 8'h4E;
  localparam byte_t CHAR_R     = 8'h52;
  localparam byte_t CHAR_A     = 8'h61;
  localparam byte_t CHAR_LOW_N = 8'h6E;
  localparam byte_t CHAR_G     = 8'h67;
  localparam byte_t CHAR_E     = 8'h65;
  localparam byte_t CHAR_SPACE = 8'h20;
  localparam byte_t CHAR_ZERO  = 8'h30;
  localparam byte_t CHAR_NINE  = 8'h39;

  localparam int unsigned PREFIX_LEN = 6;
  localparam range_t      RANGE_NONE = '1;

  // expected byte of the "Range " prefix at a given position
  function automatic byte_t range_prefix_char(input logic [2:0] pos);
    byte_t c;
    unique case (pos)
      3'd0:    c = CHAR_R;
      3'd1:    c = CHAR_A;
      3'd2:    c = CHAR_LOW_N;
      3'd3:    c = CHAR_G;
      3'd4:    c = CHAR_E;
      3'd5:    c = CHAR_SPACE;
      default: c = CHAR_SPACE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rtlp_in_if.sv =====
// received byte channel
`default_nettype none

interface rtlp_in_if;
  import rtlp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rtlp_out_if.sv =====
// parser status channel
`default_nettype none

interface rtlp_out_if;
  import rtlp_pkg::*;

  logic   valid;
  logic   ready;
  logic   presence;
  range_t range_value;
  logic   line_parsed;

  modport source (output valid, output presence, output range_value, output line_parsed,
                  input ready);
  modport sink (input valid, input presence, input range_value, input line_parsed,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/radar_text_line_parser.sv =====
// radar text line parser top level
//
//   channel   dir   payload                                 handshake
//   in_i      in    rx_byte                                 valid / ready
//   out_o     out   presence, range_value, line_parsed      valid / ready
//
// one status item per received byte, one byte per cycle sustained while out_o is ready
// registered path: input register, then parse logic into the status register
// the line state advances only when an item moves from input to status register
// a stalled status register holds its item while an empty input register still takes one
// reset clears line state, presence 0, range all ones
`default_nettype none

module radar_text_line_parser #(
  parameter int unsigned LINE_CAPACITY = 24,
  parameter int unsigned RANGE_BITS    = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rtlp_in_if.sink   in_i,
  rtlp_out_if.source out_o
);
  import rtlp_pkg::*;

  localparam int unsigned CNT_W  = $clog2(LINE_CAPACITY);
  localparam int unsigned PROD_W = RANGE_BITS + 4;
  localparam int unsigned EXT_W  = (RANGE_BITS > RANGE_W) ? RANGE_BITS : RANGE_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_PREFIX = CNT_W'(PREFIX_LEN);

  // input register
  logic  in_valid_q;
  byte_t byte_q;

  // status register
  logic   out_valid_q;
  logic   presence_out_q;
  range_t range_out_q;
  logic   parsed_out_q;

  // line state
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  off_q, off_d;
  logic                  on_q, on_d;
  logic                  prefix_q, prefix_d;
  logic                  run_open_q, run_open_d;
  logic                  digit_seen_q, digit_seen_d;
  logic [RANGE_BITS-1:0] accum_q, accum_d;
  logic                  presence_q, presence_d;
  range_t                range_q, range_d;
  logic                  parsed_d;

  logic                  advance;
  logic                  is_eol;
  logic                  is_digit;
  logic [PROD_W-1:0]     prod;
  logic [EXT_W-1:0]      accum_ext;

  assign advance   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  assign is_eol    = (byte_q == CHAR_CR) || (byte_q == CHAR_LF);
  assign is_digit  = (byte_q >= CHAR_ZERO) && (byte_q <= CHAR_NINE);
  assign prod      = PROD_W'({accum_q, 3'b000}) + PROD_W'({accum_q, 1'b0})
                   + PROD_W'(byte_q[3:0]);
  assign accum_ext = EXT_W'(accum_q);

  always_comb begin
    count_d      = count_q;
    off_d        = off_q;
    on_d         = on_q;
    prefix_d     = prefix_q;
    run_open_d   = run_open_q;
    digit_seen_d = digit_seen_q;
    accum_d      = accum_q;
    presence_d   = presence_q;
    range_d      = range_q;
    parsed_d     = 1'b0;

    if (is_eol || count_q >= CNT_LAST) begin
      // end of line or overflow: finish if non-empty eol, then restart the line
      if (is_eol && count_q != '0) begin
        parsed_d = 1'b1;
        if (off_q && count_q >= CNT_W'(3)) begin
          presence_d = 1'b0;
          range_d    = RANGE_NONE;
        end else if (on_q && count_q >= CNT_W'(2)) begin
          presence_d = 1'b1;
        end else if (prefix_q && digit_seen_q) begin
          range_d    = accum_ext[RANGE_W-1:0];
          presence_d = 1'b1;
        end
      end
      count_d      = '0;
      off_d        = 1'b0;
      on_d         = 1'b0;
      prefix_d     = 1'b0;
      run_open_d   = 1'b0;
      digit_seen_d = 1'b0;
      accum_d      = '0;
    end else begin
      count_d = count_q + CNT_W'(1);
      if (count_q == '0) begin
        off_d        = (byte_q == CHAR_O);
        on_d         = (byte_q == CHAR_O);
        prefix_d     = (byte_q == CHAR_R);
        run_open_d   = 1'b1;
        digit_seen_d = 1'b0;
        accum_d      = '0;
      end else if (count_q < CNT_PREFIX) begin
        if (count_q == CNT_W'(1)) begin
          off_d = off_q && (byte_q == CHAR_F);
          on_d  = on_q && (byte_q == CHAR_N);
        end else if (count_q == CNT_W'(2)) begin
          off_d = off_q && (byte_q == CHAR_F);
        end
        prefix_d = prefix_q && (byte_q == range_prefix_char(count_q[2:0]));
      end else if (prefix_q && run_open_q) begin
        if (is_digit) begin
          digit_seen_d = 1'b1;
          // saturate when the product spills past the range width
          if (prod[PROD_W-1:RANGE_BITS] != '0) begin
            accum_d = '1;
          end else begin
            accum_d = prod[RANGE_BITS-1:0];
          end
        end else begin
          run_open_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      off_q        <= 1'b0;
      on_q         <= 1'b0;
      prefix_q     <= 1'b0;
      run_open_q   <= 1'b0;
      digit_seen_q <= 1'b0;
      accum_q      <= '0;
      presence_q   <= 1'b0;
      range_q      <= RANGE_NONE;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q  <= 1'b1;
        count_q      <= count_d;
        off_q        <= off_d;
        on_q         <= on_d;
        prefix_q     <= prefix_d;
        run_open_q   <= run_open_d;
        digit_seen_q <= digit_seen_d;
        accum_q      <= accum_d;
        presence_q   <= presence_d;
        range_q      <= range_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.rx_byte;
    end
    if (advance) begin
      presence_out_q <= presence_d;
      range_out_q    <= range_d;
      parsed_out_q   <= parsed_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.presence    = presence_out_q;
  assign out_o.range_value = range_out_q;
  assign out_o.line_parsed = parsed_out_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_LAST)
    else $error("line count beyond capacity");

  a_absent_no_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !presence_q |-> range_q == RANGE_NONE)
    else $error("range held while no target present");

  a_digit_needs_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_seen_q |-> prefix_q)
    else $error("digit seen without range prefix");

  a_input_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(byte_q))
    else $error("input register lost a stalled item");
`endif

endmodule

`default_nettype wire
